// ===== design/bglu_pkg.sv =====
// Shared widths, constants and sequencer states for the binary GCD/LCM unit.
package bglu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int TWOS_W      = $clog2(DATA_WIDTH);
    localparam int CNT_W       = $clog2(DATA_WIDTH);
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam logic FUNC_GCD = 1'b0;
    localparam logic FUNC_LCM = 1'b1;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TWOS,
        S_ASTRIP,
        S_LOOP,
        S_GCD_END,
        S_DIV,
        S_MUL,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

// ===== design/binary_gcd_lcm_unit_top.sv =====
// Binary (Stein) GCD and LCM unit built around one shared subtractor and a small sequencer.
//
// Usage:
// The input channel (s_axis_*) carries one operation per transfer: tdata holds operand_a
// in bits [DATA_WIDTH-1:0] and operand_b above it, both two's complement, and tuser bit 0
// selects the function (0 = GCD, 1 = LCM). The output channel (m_axis_*) returns exactly
// one transfer per operation: tdata holds the signed result and tuser bit 0 is the
// special_case flag, set when the result is the forced zero of an invalid operand or of
// an LCM that does not fit the signed range.
// Sequence: operations resolved by the operand checks go from the accept straight to the
// emit step and the output register. A full GCD runs the common-twos strip, the strip of
// operand_a and the subtract/strip loop, each one step per cycle; only the loop uses the
// shared subtractor. An LCM then adds a restoring division (on the same subtractor), a
// multiply and a check of the product against the signed range.
// Throughput: one operation at a time; s_axis_tready is high only while the sequencer idles.
// The output register decouples the sides: a new operation is accepted while a result
// waits, and a finished result waits in the sequencer until the output register is free.
// Reset clears the sequencer and the output valid; no result is in flight afterwards.
module binary_gcd_lcm_unit_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: operand_a, operand_b.
    input  logic [bglu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func.
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: result.
    output logic [bglu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: special_case.
    output logic [0:0]                       m_axis_tuser
);
    import bglu_pkg::*;

    localparam int W = DATA_WIDTH;

    state_t state_reg, state_next;

    word_t              a_reg, a_next;
    word_t              b_reg, b_next;
    word_t              ma_reg, ma_next;
    word_t              mb_reg, mb_next;
    word_t              rem_reg, rem_next;
    logic [TWOS_W-1:0]  twos_reg, twos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [2*W-1:0]     prod_reg, prod_next;
    logic               func_reg, func_next;
    word_t              res_reg, res_next;
    logic               flag_reg, flag_next;
    logic               m_valid_reg, m_valid_next;
    word_t              m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    // Input decode.
    word_t in_a, in_b, mag_a, mag_b;
    logic  in_func, bad_min, a_zero, b_zero, accept, out_free;

    assign in_a    = s_axis_tdata[W-1:0];
    assign in_b    = s_axis_tdata[2*W-1:W];
    assign in_func = s_axis_tuser[0];
    assign mag_a   = in_a[W-1] ? (~in_a + word_t'(1)) : in_a;
    assign mag_b   = in_b[W-1] ? (~in_b + word_t'(1)) : in_b;
    assign bad_min = (in_a == INT_MIN) || (in_b == INT_MIN);
    assign a_zero  = (in_a == '0);
    assign b_zero  = (in_b == '0);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // The one shared subtractor: b - a in the GCD loop, the trial subtract in the division.
    logic [W:0]   sub_x, sub_y;
    logic [W+1:0] diff;
    logic         sub_neg, sub_zero;

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            sub_x = {rem_reg, ma_reg[W-1]};
            sub_y = {1'b0, b_reg};
        end
        else
        begin
            sub_x = {1'b0, b_reg};
            sub_y = {1'b0, a_reg};
        end
    end

    assign diff     = {1'b0, sub_x} - {1'b0, sub_y};
    assign sub_neg  = diff[W+1];
    assign sub_zero = (diff == '0);

    word_t gcd_val;
    logic  prod_over;

    assign gcd_val   = a_reg << twos_reg;
    assign prod_over = |prod_reg[2*W-1:W-1];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (bad_min || a_zero || b_zero)
                        state_next = S_EMIT;
                    else
                        state_next = S_TWOS;
                end
            end
            S_TWOS:
            begin
                if (a_reg[0] || b_reg[0])
                    state_next = S_ASTRIP;
            end
            S_ASTRIP:
            begin
                if (a_reg[0])
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (b_reg[0] && sub_zero)
                    state_next = S_GCD_END;
            end
            S_GCD_END:
            begin
                if (func_reg == FUNC_LCM)
                    state_next = S_DIV;
                else
                    state_next = S_EMIT;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(W - 1))
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_CHECK;
            S_CHECK: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        rem_next     = rem_reg;
        twos_next    = twos_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        func_next    = func_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_func;
                    a_next    = mag_a;
                    b_next    = mag_b;
                    ma_next   = mag_a;
                    mb_next   = mag_b;
                    twos_next = '0;
                    res_next  = '0;
                    flag_next = 1'b0;
                    if (in_func == FUNC_GCD)
                    begin
                        // One zero operand passes the other through with its sign.
                        if (bad_min || (a_zero && b_zero))
                            flag_next = 1'b1;
                        else if (a_zero)
                            res_next = in_b;
                        else if (b_zero)
                            res_next = in_a;
                    end
                    else if (bad_min || a_zero || b_zero)
                    begin
                        flag_next = 1'b1;
                    end
                end
            end
            S_TWOS:
            begin
                if (!(a_reg[0] || b_reg[0]))
                begin
                    a_next    = a_reg >> 1;
                    b_next    = b_reg >> 1;
                    twos_next = twos_reg + TWOS_W'(1);
                end
            end
            S_ASTRIP:
            begin
                if (!a_reg[0])
                    a_next = a_reg >> 1;
            end
            S_LOOP:
            begin
                if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (sub_neg)
                begin
                    // a > b: the smaller value stays, the difference is a - b.
                    a_next = b_reg;
                    b_next = ~diff[W-1:0] + word_t'(1);
                end
                else
                begin
                    b_next = diff[W-1:0];
                end
            end
            S_GCD_END:
            begin
                res_next = gcd_val;
                b_next   = gcd_val;
                rem_next = '0;
                cnt_next = '0;
            end
            S_DIV:
            begin
                // Restoring division of |a| by the GCD; the quotient shifts into ma_reg.
                if (sub_neg)
                    rem_next = sub_x[W-1:0];
                else
                    rem_next = diff[W-1:0];
                ma_next  = {ma_reg[W-2:0], !sub_neg};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_MUL:
            begin
                prod_next = {{W{1'b0}}, ma_reg} * {{W{1'b0}}, mb_reg};
            end
            S_CHECK:
            begin
                if (prod_over)
                begin
                    res_next  = '0;
                    flag_next = 1'b1;
                end
                else
                begin
                    res_next = prod_reg[W-1:0];
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = flag_reg;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        rem_reg    <= rem_next;
        twos_reg   <= twos_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        func_reg   <= func_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_data_reg);
    assign m_axis_tuser  = m_user_reg;

    // A flagged result is always the forced zero.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg) |-> (m_data_reg == '0))
        else $error("special_case result is not zero");

    // The subtract loop only runs while b holds a nonzero value.
    a_loop_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (b_reg != '0))
        else $error("GCD loop entered with b equal to zero");

    // The division never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (b_reg != '0))
        else $error("division by zero GCD");

    // An accepted operation blocks the input until it has been handed to the output.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input ready right after an accepted transfer");

    // The output register is loaded only from the emit step.
    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("output loaded outside the emit step");

endmodule
